// ===== rtl/bale_pkg.sv =====
// ----------------------------------------------------------------------------
// bale_pkg
// Shared types, codes and defaults for the bounded array list engine.
// ----------------------------------------------------------------------------
package bale_pkg;

  localparam int unsigned DefCapacity = 16;

  // request kinds; code 7 is unused and completes with ok
  typedef enum logic [2:0] {
    REQ_APPEND  = 3'd0,
    REQ_INSERT  = 3'd1,
    REQ_REM_AT  = 3'd2,
    REQ_REM_VAL = 3'd3,
    REQ_FIND    = 3'd4,
    REQ_STATS   = 3'd5,
    REQ_CLEAR   = 3'd6
  } req_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_BAD_INDEX = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    IDX_HOLD = 3'd0,
    IDX_INC  = 3'd1,
    IDX_DEC  = 3'd2,
    IDX_POS  = 3'd3,
    IDX_ZERO = 3'd4
  } idx_op_e;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2,
    CNT_CLR  = 2'd3
  } cnt_op_e;

  typedef enum logic [1:0] {
    RD_IDX = 2'd0,
    RD_DN  = 2'd1,
    RD_UP  = 2'd2
  } rd_sel_e;

  typedef enum logic {
    WR_VAL = 1'b0,
    WR_MEM = 1'b1
  } wr_src_e;

  // controller to datapath
  typedef struct packed {
    logic    load;
    idx_op_e idx_op;
    cnt_op_e cnt_op;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_src_e wr_src;
    logic    set_status;
    status_e status_code;
    logic    found_wr;
    logic    acc_init;
    logic    acc_upd;
    logic    div_start;
    logic    mean_wr;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] req_type;
    logic       full;
    logic       pos_gt_cnt;
    logic       pos_ge_cnt;
    logic       cnt_zero;
    logic       idx_gt_pos;
    logic       idx_p1_lt_cnt;
    logic       idx_lt_cnt;
    logic       match;
    logic       div_done;
  } sts_t;

endpackage

// ===== rtl/bounded_array_list_engine.sv =====
// ----------------------------------------------------------------------------
// bounded_array_list_engine
// Bounded list of signed 32-bit values with append, insert, remove, find,
// statistics and clear; one result per transaction.
// Clear and unused kinds go straight to the result; append writes once;
//   insert and remove at index take a read and a write per shifted entry;
//   find and remove by value take a read and a check per scanned entry;
//   stats walk every entry, then run the serial divider for the mean.
// One transaction at a time; busy stays high until the result strobe.
// Result is shown one cycle on done_o; the receiver cannot stall.
// Reset clears count and control; entry RAM holds no reset and is not swept.
// ----------------------------------------------------------------------------
module bounded_array_list_engine
  import bale_pkg::*;
#(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         req_type_i,
  input  logic signed [31:0] value_i,
  input  logic [3:0]         position_i,
  output logic               done_o,
  output logic [2:0]         status_o,
  output logic [3:0]         found_index_o,
  output logic [4:0]         item_count_o,
  output logic signed [31:0] largest_o,
  output logic signed [31:0] smallest_o,
  output logic signed [35:0] total_o,
  output logic signed [31:0] mean_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  bale_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .done_o(done_o),
    .sts_i (sts),
    .cmd_o (cmd)
  );

  // storage and arithmetic
  bale_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_type_i   (req_type_i),
    .value_i      (value_i),
    .position_i   (position_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .status_o     (status_o),
    .found_index_o(found_index_o),
    .item_count_o (item_count_o),
    .largest_o    (largest_o),
    .smallest_o   (smallest_o),
    .total_o      (total_o),
    .mean_o       (mean_o)
  );

endmodule

// ===== rtl/bale_ram.sv =====
// ----------------------------------------------------------------------------
// bale_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module bale_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/bale_dp.sv =====
// ----------------------------------------------------------------------------
// bale_dp
// Datapath: request registers, index and count, entry RAM, statistics
// accumulators, serial divider for the mean and result registers.
// ----------------------------------------------------------------------------
module bale_dp
  import bale_pkg::*;
#(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [2:0]         req_type_i,
  input  logic signed [31:0] value_i,
  input  logic [3:0]         position_i,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  output logic [2:0]         status_o,
  output logic [3:0]         found_index_o,
  output logic [4:0]         item_count_o,
  output logic signed [31:0] largest_o,
  output logic signed [31:0] smallest_o,
  output logic signed [35:0] total_o,
  output logic signed [31:0] mean_o
);

  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CmpW  = CntW + 4;
  localparam int unsigned SumW  = 32 + CntW;
  localparam int unsigned StepW = $clog2(SumW + 1);

  logic [2:0]             type_q;
  logic [31:0]            val_q;
  logic [3:0]             pos_q;
  logic [CntW-1:0]        idx_q, idx_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [2:0]             status_q;
  logic [CntW-1:0]        found_q;
  logic signed [31:0]     big_q, small_q, mean_q;
  logic signed [SumW-1:0] sum_q;
  logic [CntW:0]          rem_q;
  logic [SumW-1:0]        quo_q;
  logic                   neg_q;
  logic [StepW-1:0]       step_q;

  logic [31:0]            rdata;
  logic [CntW-1:0]        raddr;
  logic [31:0]            wdata;
  logic signed [31:0]     elem;
  logic [CntW:0]          shifted;
  logic                   ge;
  logic [SumW-1:0]        mag;
  logic [SumW-1:0]        qsigned;
  logic [CntW:0]          idx_p1;
  logic [CmpW-1:0]        pos_w, cnt_w, idx_w, found_w;
  logic [SumW+35:0]       tot_w;

  // latch the request on accept
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      type_q <= req_type_i;
      val_q  <= value_i;
      pos_q  <= position_i;
    end
  end

  // select next index and count
  always_comb begin
    idx_d = idx_q;
    case (cmd_i.idx_op)
      IDX_INC:  idx_d = idx_q + 1'b1;
      IDX_DEC:  idx_d = idx_q - 1'b1;
      IDX_POS:  idx_d = CntW'(pos_q);
      IDX_ZERO: idx_d = '0;
      default:  idx_d = idx_q;
    endcase
    if (cmd_i.load) begin
      idx_d = cnt_q;
    end
    cnt_d = cnt_q;
    case (cmd_i.cnt_op)
      CNT_INC: cnt_d = cnt_q + 1'b1;
      CNT_DEC: cnt_d = cnt_q - 1'b1;
      CNT_CLR: cnt_d = '0;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      cnt_q <= '0;
    end else begin
      idx_q <= idx_d;
      cnt_q <= cnt_d;
    end
  end

  // entry storage
  always_comb begin
    case (cmd_i.rd_sel)
      RD_DN:   raddr = idx_q - 1'b1;
      RD_UP:   raddr = idx_q + 1'b1;
      default: raddr = idx_q;
    endcase
  end

  assign wdata = (cmd_i.wr_src == WR_MEM) ? rdata : val_q;

  bale_ram #(
    .Width(32),
    .Depth(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en),
    .waddr_i(idx_q[IdxW-1:0]),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(raddr[IdxW-1:0]),
    .rdata_o(rdata)
  );

  // result registers and statistics accumulators
  assign elem = $signed(rdata);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= ST_OK;
    end else if (cmd_i.load) begin
      status_q <= ST_OK;
    end else if (cmd_i.set_status) begin
      status_q <= cmd_i.status_code;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      found_q <= '0;
      big_q   <= '0;
      small_q <= '0;
      sum_q   <= '0;
      mean_q  <= '0;
    end else begin
      if (cmd_i.found_wr) begin
        found_q <= idx_q;
      end
      if (cmd_i.acc_init) begin
        big_q   <= 32'sh8000_0000;
        small_q <= 32'sh7fff_ffff;
        sum_q   <= '0;
      end else if (cmd_i.acc_upd) begin
        if (elem > big_q) begin
          big_q <= elem;
        end
        if (elem < small_q) begin
          small_q <= elem;
        end
        sum_q <= sum_q + SumW'(elem);
      end
      if (cmd_i.mean_wr) begin
        mean_q <= $signed(qsigned[31:0]);
      end
    end
  end

  // restoring divider: one quotient bit per cycle
  assign mag     = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
  assign shifted = {rem_q[CntW-1:0], quo_q[SumW-1]};
  assign ge      = shifted >= {1'b0, cnt_q};
  assign qsigned = neg_q ? (~quo_q + 1'b1) : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.div_start) begin
      step_q <= StepW'(SumW);
    end else if (step_q != '0) begin
      step_q <= step_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= mag;
      neg_q <= sum_q[SumW-1];
    end else if (step_q != '0) begin
      rem_q <= ge ? (shifted - {1'b0, cnt_q}) : shifted;
      quo_q <= {quo_q[SumW-2:0], ge};
    end
  end

  // status toward the controller
  assign pos_w  = CmpW'(pos_q);
  assign cnt_w  = CmpW'(cnt_q);
  assign idx_w  = CmpW'(idx_q);
  assign idx_p1 = {1'b0, idx_q} + 1'b1;

  assign sts_o.req_type      = type_q;
  assign sts_o.full          = cnt_q >= CntW'(CAPACITY);
  assign sts_o.pos_gt_cnt    = pos_w > cnt_w;
  assign sts_o.pos_ge_cnt    = pos_w >= cnt_w;
  assign sts_o.cnt_zero      = cnt_q == '0;
  assign sts_o.idx_gt_pos    = idx_w > pos_w;
  assign sts_o.idx_p1_lt_cnt = idx_p1 < {1'b0, cnt_q};
  assign sts_o.idx_lt_cnt    = idx_q < cnt_q;
  assign sts_o.match         = rdata == val_q;
  assign sts_o.div_done      = step_q == '0;

  // result ports
  assign found_w       = CmpW'(found_q);
  assign tot_w         = (SumW + 36)'(sum_q);
  assign status_o      = status_q;
  assign found_index_o = found_w[3:0];
  assign item_count_o  = cnt_w[4:0];
  assign largest_o     = big_q;
  assign smallest_o    = small_q;
  assign total_o       = $signed(tot_w[35:0]);
  assign mean_o        = mean_q;

endmodule

// ===== rtl/bale_ctrl.sv =====
// ----------------------------------------------------------------------------
// bale_ctrl
// Controller: sequences search, shift, statistics and divide steps.
// ----------------------------------------------------------------------------
module bale_ctrl
  import bale_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  output logic done_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_INS_CHK  = 4'd2;
  localparam logic [3:0] S_INS_WR   = 4'd3;
  localparam logic [3:0] S_INS_PUT  = 4'd4;
  localparam logic [3:0] S_DEL_CHK  = 4'd5;
  localparam logic [3:0] S_DEL_WR   = 4'd6;
  localparam logic [3:0] S_SCAN_RD  = 4'd7;
  localparam logic [3:0] S_SCAN_CHK = 4'd8;
  localparam logic [3:0] S_DIV      = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  logic [3:0] state_q, state_d;

  // next state and command decode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_DONE;
        case (sts_i.req_type)
          REQ_APPEND: begin
            if (sts_i.full) begin
              cmd_o.set_status  = 1'b1;
              cmd_o.status_code = ST_FULL;
            end else begin
              state_d = S_INS_PUT;
            end
          end
          REQ_INSERT: begin
            if (sts_i.full) begin
              cmd_o.set_status  = 1'b1;
              cmd_o.status_code = ST_FULL;
            end else if (sts_i.pos_gt_cnt) begin
              cmd_o.set_status  = 1'b1;
              cmd_o.status_code = ST_BAD_INDEX;
            end else begin
              state_d = S_INS_CHK;
            end
          end
          REQ_REM_AT: begin
            if (sts_i.pos_ge_cnt) begin
              cmd_o.set_status  = 1'b1;
              cmd_o.status_code = ST_BAD_INDEX;
            end else begin
              cmd_o.idx_op = IDX_POS;
              state_d      = S_DEL_CHK;
            end
          end
          REQ_REM_VAL, REQ_FIND: begin
            cmd_o.idx_op = IDX_ZERO;
            state_d      = S_SCAN_RD;
          end
          REQ_STATS: begin
            if (sts_i.cnt_zero) begin
              cmd_o.set_status  = 1'b1;
              cmd_o.status_code = ST_EMPTY;
            end else begin
              cmd_o.idx_op   = IDX_ZERO;
              cmd_o.acc_init = 1'b1;
              state_d        = S_SCAN_RD;
            end
          end
          REQ_CLEAR: begin
            cmd_o.cnt_op = CNT_CLR;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      // shift up from the top, one entry per read and write pair
      S_INS_CHK: begin
        if (sts_i.idx_gt_pos) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_DN;
          state_d      = S_INS_WR;
        end else begin
          state_d = S_INS_PUT;
        end
      end
      S_INS_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_src = WR_MEM;
        cmd_o.idx_op = IDX_DEC;
        state_d      = S_INS_CHK;
      end
      S_INS_PUT: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_src = WR_VAL;
        cmd_o.cnt_op = CNT_INC;
        state_d      = S_DONE;
      end
      // shift down over the removed slot
      S_DEL_CHK: begin
        if (sts_i.idx_p1_lt_cnt) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_UP;
          state_d      = S_DEL_WR;
        end else begin
          cmd_o.cnt_op = CNT_DEC;
          state_d      = S_DONE;
        end
      end
      S_DEL_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_src = WR_MEM;
        cmd_o.idx_op = IDX_INC;
        state_d      = S_DEL_CHK;
      end
      // walk the stored entries
      S_SCAN_RD: begin
        if (sts_i.idx_lt_cnt) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_IDX;
          state_d      = S_SCAN_CHK;
        end else if (sts_i.req_type == REQ_STATS) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          cmd_o.set_status  = 1'b1;
          cmd_o.status_code = ST_NOT_FOUND;
          state_d           = S_DONE;
        end
      end
      S_SCAN_CHK: begin
        if (sts_i.req_type == REQ_STATS) begin
          cmd_o.acc_upd = 1'b1;
          cmd_o.idx_op  = IDX_INC;
          state_d       = S_SCAN_RD;
        end else if (sts_i.match) begin
          if (sts_i.req_type == REQ_FIND) begin
            cmd_o.found_wr = 1'b1;
            state_d        = S_DONE;
          end else begin
            state_d = S_DEL_CHK;
          end
        end else begin
          cmd_o.idx_op = IDX_INC;
          state_d      = S_SCAN_RD;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.mean_wr = 1'b1;
          state_d       = S_DONE;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy   = state_q != S_IDLE;
  assign done_o = state_q == S_DONE;

  // an accepted transaction is decoded in the next cycle
  a_accept_decode : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == S_DECODE))
    else $error("accepted transaction not decoded");

  // a result strobe lasts one cycle and frees the block
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("block still busy after result");

  // never write a new value into a full list
  a_put_not_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS_PUT) |-> !sts_i.full)
    else $error("value placed into full list");

  // the divider runs only after the statistics walk
  a_div_stats : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (sts_i.req_type == REQ_STATS))
    else $error("divider used outside statistics");

endmodule

// ===== verif/bounded_array_list_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_array_list_engine_tb
// Self-checking bench for the list engine: a directed table of requests,
// then random request streams checked against a behavioral list model.
// ----------------------------------------------------------------------------
module bounded_array_list_engine_tb;
  import bale_pkg::*;

  localparam int unsigned Cap = DefCapacity;
  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles = 200;

  typedef struct {
    logic [2:0]         status;
    logic [3:0]         found_index;
    logic [4:0]         item_count;
    logic signed [31:0] largest;
    logic signed [31:0] smallest;
    logic signed [35:0] total;
    logic signed [31:0] mean;
  } list_resp_t;

  typedef struct {
    logic [2:0]         kind;
    logic signed [31:0] value;
    logic [3:0]         position;
    bit                 typed;
    logic [2:0]         status;
    logic [4:0]         item_count;
  } dir_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         req_type_i = '0;
  logic signed [31:0] value_i = '0;
  logic [3:0]         position_i = '0;
  logic               done_o;
  logic [2:0]         status_o;
  logic [3:0]         found_index_o;
  logic [4:0]         item_count_o;
  logic signed [31:0] largest_o;
  logic signed [31:0] smallest_o;
  logic signed [35:0] total_o;
  logic signed [31:0] mean_o;

  // model state
  logic signed [31:0] list_mem [Cap];
  int unsigned        list_len;
  list_resp_t         resp_q [$];
  int unsigned        err_cnt = 0;
  int unsigned        idle_cycles = 0;
  int unsigned        sender_gap_pct = 29;
  logic signed [31:0] val_pool [8];

  bounded_array_list_engine u_dut (
    .clk_i, .rst_ni, .start, .busy, .req_type_i, .value_i, .position_i,
    .done_o, .status_o, .found_index_o, .item_count_o, .largest_o,
    .smallest_o, .total_o, .mean_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // compute the response of one request and update the model list
  function automatic list_resp_t model_list_req(logic [2:0] kind, logic signed [31:0] v,
                                                logic [3:0] pos);
    list_resp_t r;
    int hit;
    logic signed [35:0] acc;
    r = '{default: '0};
    hit = -1;
    if (kind == REQ_REM_VAL || kind == REQ_FIND)
      for (int i = list_len - 1; i >= 0; i--)
        if (list_mem[i] == v) hit = i;
    case (kind)
      REQ_APPEND: begin
        if (list_len >= Cap) r.status = ST_FULL;
        else begin
          list_mem[list_len] = v;
          list_len++;
        end
      end
      REQ_INSERT: begin
        if (list_len >= Cap) r.status = ST_FULL;
        else if (pos > list_len) r.status = ST_BAD_INDEX;
        else begin
          for (int i = list_len; i > pos; i--) list_mem[i] = list_mem[i-1];
          list_mem[pos] = v;
          list_len++;
        end
      end
      REQ_REM_AT, REQ_REM_VAL: begin
        if (kind == REQ_REM_AT) hit = (pos < list_len) ? int'(pos) : -1;
        if (hit < 0) r.status = (kind == REQ_REM_AT) ? ST_BAD_INDEX : ST_NOT_FOUND;
        else begin
          for (int i = hit; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      REQ_FIND: begin
        if (hit < 0) r.status = ST_NOT_FOUND;
        else r.found_index = hit[3:0];
      end
      REQ_STATS: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else begin
          r.largest = list_mem[0];
          r.smallest = list_mem[0];
          acc = '0;
          for (int i = 0; i < list_len; i++) begin
            if (list_mem[i] > r.largest) r.largest = list_mem[i];
            if (list_mem[i] < r.smallest) r.smallest = list_mem[i];
            acc += 36'(list_mem[i]);
          end
          r.total = acc;
          r.mean = 32'(acc / $signed({1'b0, 5'(list_len)}));
        end
      end
      REQ_CLEAR: list_len = 0;
      default: ;
    endcase
    r.item_count = list_len[4:0];
    return r;
  endfunction

  // issue one transaction and record its expected response
  task automatic send_req(logic [2:0] kind, logic signed [31:0] v, logic [3:0] pos,
                          bit gaps);
    while (gaps && $urandom_range(99) < sender_gap_pct) @(posedge clk_i);
    start      <= 1'b1;
    req_type_i <= kind;
    value_i    <= v;
    position_i <= pos;
    resp_q.push_back(model_list_req(kind, v, pos));
    // the block is idle here, so the next edge takes the transaction
    @(posedge clk_i);
    start <= 1'b0;
    // wait for the strobe so busy is low for the next request
    while (resp_q.size() != 0) @(posedge clk_i);
  endtask

  // compare each result against the oldest expectation
  always @(posedge clk_i) begin
    list_resp_t e;
    if (done_o) begin
      if (resp_q.size() == 0) begin
        $display("%0t: unexpected result, status %0d", $time, status_o);
        err_cnt++;
      end else begin
        e = resp_q.pop_front();
        if (status_o !== e.status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, status_o);
          err_cnt++;
        end
        if (found_index_o !== e.found_index) begin
          $display("%0t: found_index exp %0d got %0d", $time, e.found_index, found_index_o);
          err_cnt++;
        end
        if (item_count_o !== e.item_count) begin
          $display("%0t: item_count exp %0d got %0d", $time, e.item_count, item_count_o);
          err_cnt++;
        end
        if (largest_o !== e.largest) begin
          $display("%0t: largest exp %0d got %0d", $time, e.largest, largest_o);
          err_cnt++;
        end
        if (smallest_o !== e.smallest) begin
          $display("%0t: smallest exp %0d got %0d", $time, e.smallest, smallest_o);
          err_cnt++;
        end
        if (total_o !== e.total) begin
          $display("%0t: total exp %0d got %0d", $time, e.total, total_o);
          err_cnt++;
        end
        if (mean_o !== e.mean) begin
          $display("%0t: mean exp %0d got %0d", $time, e.mean, mean_o);
          err_cnt++;
        end
      end
    end
  end

  // end the run when nothing is accepted for too long
  always @(posedge clk_i) begin
    if (done_o || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_val();
    case ($urandom_range(3))
      0: return val_pool[$urandom_range(7)];
      1: return $signed($urandom_range(20)) - 10;
      default: return $signed($urandom());
    endcase
  endfunction

  initial begin
    dir_row_t rows [$];
    list_resp_t chk;
    logic signed [31:0] mx, mn;
    logic [2:0] k;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    // empty list cases, extremes, fill to capacity, then full, stats, remove and clear
    rows.push_back('{REQ_STATS, 0, 0, 1, ST_EMPTY, 0});
    rows.push_back('{REQ_REM_AT, 0, 0, 1, ST_BAD_INDEX, 0});
    rows.push_back('{REQ_REM_VAL, 5, 0, 1, ST_NOT_FOUND, 0});
    rows.push_back('{REQ_FIND, 5, 0, 1, ST_NOT_FOUND, 0});
    rows.push_back('{REQ_INSERT, 7, 4'd1, 1, ST_BAD_INDEX, 0});
    rows.push_back('{REQ_APPEND, mx, 0, 1, ST_OK, 1});
    rows.push_back('{REQ_APPEND, mn, 0, 1, ST_OK, 2});
    rows.push_back('{REQ_INSERT, -1, 4'd0, 1, ST_OK, 3});
    rows.push_back('{REQ_INSERT, 9, 4'd3, 1, ST_OK, 4});
    rows.push_back('{REQ_STATS, 0, 0, 0, 0, 0});
    rows.push_back('{REQ_FIND, mn, 0, 0, 0, 0});
    rows.push_back('{REQ_REM_VAL, -1, 0, 0, 0, 0});
    rows.push_back('{REQ_REM_AT, 0, 4'd2, 0, 0, 0});
    rows.push_back('{3'd7, 0, 4'd15, 1, ST_OK, 2});
    for (int i = 0; i < 14; i++) rows.push_back('{REQ_APPEND, mx, 0, 0, 0, 0});
    rows.push_back('{REQ_APPEND, 1, 0, 1, ST_FULL, 16});
    rows.push_back('{REQ_INSERT, 1, 4'd15, 1, ST_FULL, 16});
    rows.push_back('{REQ_STATS, 0, 0, 0, 0, 0});
    rows.push_back('{REQ_REM_AT, 0, 4'd15, 0, 0, 0});
    rows.push_back('{REQ_CLEAR, 0, 0, 1, ST_OK, 0});
    list_len = 0;
    foreach (val_pool[i]) val_pool[i] = $signed($urandom());
    val_pool[0] = mx;
    val_pool[1] = mn;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (rows[i]) begin
      if (rows[i].typed) begin
        chk = model_list_req(rows[i].kind, rows[i].value, rows[i].position);
        list_len = 0;
        // rebuild model by replaying typed rows is avoided: typed rows only
        // carry fields the model also yields, so check the two agree
        if (chk.status !== rows[i].status || chk.item_count !== rows[i].item_count) begin
          $display("%0t: table row %0d exp %0d/%0d model %0d/%0d", $time, i,
                   rows[i].status, rows[i].item_count, chk.status, chk.item_count);
          err_cnt++;
        end
        list_len = chk.item_count;
        // undo the model step; send_req applies it again
        if (rows[i].kind == REQ_APPEND && chk.status == ST_OK) list_len--;
        if (rows[i].kind == REQ_INSERT && chk.status == ST_OK) begin
          for (int j = rows[i].position; j + 1 < list_len; j++) list_mem[j] = list_mem[j+1];
          list_len--;
        end
        if (rows[i].kind == REQ_CLEAR) list_len = 2;
      end
      send_req(rows[i].kind, rows[i].value, rows[i].position, 1'b0);
    end

    // random phases: sender idles 29%, then 54%, then never
    for (int ph = 0; ph < 3; ph++) begin
      sender_gap_pct = (ph == 0) ? 29 : (ph == 1) ? 54 : 0;
      for (int n = 0; n < 140; n++) begin
        if ($urandom_range(9) < 8) begin
          // list-shaped traffic: bias toward growth, then searches
          case ($urandom_range(9))
            0, 1, 2: k = REQ_APPEND;
            3, 4:    k = REQ_INSERT;
            5:       k = REQ_REM_AT;
            6:       k = REQ_REM_VAL;
            7:       k = REQ_FIND;
            default: k = REQ_STATS;
          endcase
          if ((k == REQ_REM_VAL || k == REQ_FIND) && list_len > 0 && $urandom_range(1))
            send_req(k, list_mem[$urandom_range(list_len - 1)], 4'($urandom()), 1'b1);
          else
            send_req(k, rand_val(), (list_len > 0 && $urandom_range(1)) ?
                     4'($urandom_range(list_len)) : 4'($urandom()), 1'b1);
        end else begin
          send_req(3'($urandom()), rand_val(), 4'($urandom()), 1'b1);
        end
        // pause the sender once per phase; every result is already in by then
        if (n == 75) repeat (40) @(posedge clk_i);
      end
    end

    while (resp_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
